// File: src/qfit_pkg.sv
// shared constants and types for the three-point quadratic fit
`timescale 1ns / 1ps
package qfit_pkg;

  localparam int FIELD_W = 16;           // width of one coordinate field
  localparam int OUT_W = 32;             // width of one coefficient
  localparam int QB = OUT_W + 1;         // quotient bits kept by the divider
  localparam int DIV_LAT = QB + 2;       // divider register stages
  localparam int SPACING_W = 16;
  localparam int DET_EPS_W = 40;
  localparam int CFG_W = 40;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_COORD_FRAC = 8;
  localparam int DEF_COEF_FRAC = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPACING_EPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DET_EPS = 1'b1;

  typedef enum logic [1:0] {
    FIT_OK = 2'd0,
    FIT_CLOSE = 2'd1,
    FIT_DET_SMALL = 2'd2
  } fit_status_t;

endpackage

// File: src/qfit_divider.sv
// pipelined restoring divider, one quotient bit per stage, with saturation
`timescale 1ns / 1ps
module qfit_divider import qfit_pkg::*; #(
  parameter int NUM_W = 67,
  parameter int DEN_W = 51,
  parameter int SHIFT = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_mag,
  input  logic             neg,
  input  logic [DEN_W-1:0] den,
  input  logic             refuse,
  output logic [OUT_W-1:0] quo,
  output logic             sat
);

  localparam int UP = (SHIFT > 0) ? SHIFT : 0;
  localparam int DN = (SHIFT < 0) ? -SHIFT : 0;
  localparam int EW = NUM_W + UP;
  localparam int HW = EW - QB;
  localparam int CMPW = (HW > DEN_W) ? HW : DEN_W;
  localparam logic [QB-1:0] LIM = QB'(1) << (OUT_W - 1);

  logic [EW-1:0] ext;
  logic [HW-1:0] hi;

  logic [DEN_W-1:0] r  [QB];
  logic [QB-1:0]    lo [QB];
  logic [DEN_W-1:0] dd [QB];
  logic [QB-1:0]    q  [QB+1];
  logic             ng [QB+1];
  logic             ov [QB+1];
  logic             rf [QB+1];

  // scale the numerator by the fraction shift, then split off the part above the quotient
  assign ext = (EW'(num_mag) << UP) >> DN;
  assign hi = ext[EW-1:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= DEN_W'(hi);
      ov[0] <= CMPW'(hi) >= CMPW'(den);
      lo[0] <= ext[QB-1:0];
      dd[0] <= den;
      q[0]  <= '0;
      ng[0] <= neg;
      rf[0] <= refuse;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;
    assign t = {r[k], lo[k][QB-1-k]};
    assign diff = t - {1'b0, dd[k]};
    assign ge = t >= {1'b0, dd[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        q[k+1]  <= {q[k][QB-2:0], ge};
        ng[k+1] <= ng[k];
        ov[k+1] <= ov[k];
        rf[k+1] <= rf[k];
      end
    end

    if (k < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r[k+1]  <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
          lo[k+1] <= lo[k];
          dd[k+1] <= dd[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rf[QB]) begin
        quo <= '0;
        sat <= 1'b0;
      end else if (ov[QB] || (ng[QB] && q[QB] > LIM) || (!ng[QB] && q[QB] > LIM - QB'(1))) begin
        quo <= ng[QB] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        sat <= 1'b1;
      end else begin
        quo <= ng[QB] ? -q[QB][OUT_W-1:0] : q[QB][OUT_W-1:0];
        sat <= 1'b0;
      end
    end
  end

endmodule

// File: src/quadratic_fit_three_points.sv
// top level of the three-point quadratic fit by cramer's rule
`timescale 1ns / 1ps
// usage:
//   s_axis carries one transaction per fit: three points (x, y), six 16-bit
//   signed fields. m_axis returns one transaction per fit: coefficients a, b, c
//   in tdata and fit status plus saturation flag in tuser.
//   cfg_we/cfg_index/cfg_wdata write spacing_eps (index 0) and det_eps
//   (index 1); write them only while no fit is in flight.
// pipeline: 6 arithmetic stages (differences, products, determinant,
//   numerators, sums, magnitudes) plus 35 divider stages.
// throughput: one fit per cycle unless stalled; the three divisions run in
//   parallel restoring dividers that resolve one quotient bit per stage.
// stall: the whole pipeline holds while a result waits at the output and
//   m_axis_tready is low; s_axis_tready follows that, nothing is dropped.
// reset: rst clears all valid bits and both threshold registers to zero;
//   s_axis_tready stays low while rst is high.
// refused fits (x values too close, determinant too small) give zero
//   coefficients and a nonzero status.
module quadratic_fit_three_points import qfit_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int COORD_FRAC = DEF_COORD_FRAC,
  parameter int COEF_FRAC = DEF_COEF_FRAC
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  logic [6*FIELD_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // coef_a, coef_b, coef_c
  output logic [3*OUT_W-1:0]   m_axis_tdata,
  // fit_status, saturated
  output logic [2:0]           m_axis_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // coordinate width actually used, capped at the field width
  localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int DW = CW + 1;          // x difference
  localparam int PW = 2 * DW;          // product of two differences
  localparam int SW = 2 * CW;          // x products and squares
  localparam int YW = CW + DW;         // y times difference
  localparam int AW = YW + 2;          // numerator of a
  localparam int SDW = SW + 1;         // difference of squares
  localparam int BW = CW + SDW;        // y times difference of squares
  localparam int NBW = BW + 2;         // numerator of b
  localparam int YCW = CW + SW;        // y times x product
  localparam int TW = YCW + DW;        // term of c numerator
  localparam int NCW = TW + 2;         // numerator of c
  localparam int NUM_W = NCW;
  localparam int DEN_W = 3 * DW;       // determinant
  localparam int NV = 6 + DIV_LAT;

  logic en;
  logic [NV-1:0] v;

  logic [SPACING_W-1:0] spacing_eps;
  logic [DET_EPS_W-1:0] det_eps;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_eps <= '0;
      det_eps <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPACING_EPS: spacing_eps <= cfg_wdata[SPACING_W-1:0];
        REG_DET_EPS:     det_eps <= cfg_wdata[DET_EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // the pipeline advances unless a finished result is blocked
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NV-2:0], s_axis_tvalid};
    end
  end

  // field extraction, sign-extended from CW bits
  logic signed [CW-1:0] in_x0, in_y0, in_x1, in_y1, in_x2, in_y2;
  assign in_x0 = $signed(s_axis_tdata[0*FIELD_W +: CW]);
  assign in_y0 = $signed(s_axis_tdata[1*FIELD_W +: CW]);
  assign in_x1 = $signed(s_axis_tdata[2*FIELD_W +: CW]);
  assign in_y1 = $signed(s_axis_tdata[3*FIELD_W +: CW]);
  assign in_x2 = $signed(s_axis_tdata[4*FIELD_W +: CW]);
  assign in_y2 = $signed(s_axis_tdata[5*FIELD_W +: CW]);

  // stage 1: registered coordinates and pairwise differences
  logic signed [CW-1:0] x0_1, x1_1, x2_1, y0_1, y1_1, y2_1;
  logic signed [DW-1:0] d01_1, d02_1, d12_1;

  always_ff @(posedge clk) begin
    if (en) begin
      x0_1 <= in_x0;
      x1_1 <= in_x1;
      x2_1 <= in_x2;
      y0_1 <= in_y0;
      y1_1 <= in_y1;
      y2_1 <= in_y2;
      d01_1 <= DW'(in_x0) - DW'(in_x1);
      d02_1 <= DW'(in_x0) - DW'(in_x2);
      d12_1 <= DW'(in_x1) - DW'(in_x2);
    end
  end

  // stage 2: spacing test and first products
  logic [DW-1:0] m01, m02, m12;
  assign m01 = $unsigned(d01_1[DW-1] ? -d01_1 : d01_1);
  assign m02 = $unsigned(d02_1[DW-1] ? -d02_1 : d02_1);
  assign m12 = $unsigned(d12_1[DW-1] ? -d12_1 : d12_1);

  logic close_2;
  logic signed [PW-1:0] p_2;
  logic signed [SW-1:0] sq0_2, sq1_2, sq2_2, x12_2, x02_2, x01_2;
  logic signed [YW-1:0] ya0_2, ya1_2, ya2_2;
  logic signed [CW-1:0] y0_2, y1_2, y2_2;
  logic signed [DW-1:0] d01_2, d02_2, d12_2;

  always_ff @(posedge clk) begin
    if (en) begin
      close_2 <= (32'(m01) <= 32'(spacing_eps)) || (32'(m02) <= 32'(spacing_eps))
              || (32'(m12) <= 32'(spacing_eps));
      p_2 <= PW'(d01_1) * PW'(d02_1);
      sq0_2 <= SW'(x0_1) * SW'(x0_1);
      sq1_2 <= SW'(x1_1) * SW'(x1_1);
      sq2_2 <= SW'(x2_1) * SW'(x2_1);
      x12_2 <= SW'(x1_1) * SW'(x2_1);
      x02_2 <= SW'(x0_1) * SW'(x2_1);
      x01_2 <= SW'(x0_1) * SW'(x1_1);
      ya0_2 <= YW'(y0_1) * YW'(d12_1);
      ya1_2 <= YW'(y1_1) * YW'(d02_1);
      ya2_2 <= YW'(y2_1) * YW'(d01_1);
      y0_2 <= y0_1;
      y1_2 <= y1_1;
      y2_2 <= y2_1;
      d01_2 <= d01_1;
      d02_2 <= d02_1;
      d12_2 <= d12_1;
    end
  end

  // stage 3: determinant, numerator of a, square differences, y times x products
  logic close_3;
  logic signed [DEN_W-1:0] det_3;
  logic signed [AW-1:0] na_3;
  logic signed [SDW-1:0] sd12_3, sd02_3, sd01_3;
  logic signed [YCW-1:0] yc0_3, yc1_3, yc2_3;
  logic signed [CW-1:0] y0_3, y1_3, y2_3;
  logic signed [DW-1:0] d01_3, d02_3, d12_3;

  always_ff @(posedge clk) begin
    if (en) begin
      close_3 <= close_2;
      det_3 <= DEN_W'(p_2) * DEN_W'(d12_2);
      na_3 <= AW'(ya0_2) - AW'(ya1_2) + AW'(ya2_2);
      sd12_3 <= SDW'(sq1_2) - SDW'(sq2_2);
      sd02_3 <= SDW'(sq0_2) - SDW'(sq2_2);
      sd01_3 <= SDW'(sq0_2) - SDW'(sq1_2);
      yc0_3 <= YCW'(y0_2) * YCW'(x12_2);
      yc1_3 <= YCW'(y1_2) * YCW'(x02_2);
      yc2_3 <= YCW'(y2_2) * YCW'(x01_2);
      y0_3 <= y0_2;
      y1_3 <= y1_2;
      y2_3 <= y2_2;
      d01_3 <= d01_2;
      d02_3 <= d02_2;
      d12_3 <= d12_2;
    end
  end

  // stage 4: determinant magnitude and test, product terms of b and c
  logic [DEN_W-1:0] dm_c;
  assign dm_c = $unsigned(det_3[DEN_W-1] ? -det_3 : det_3);

  logic close_4, small_4, dneg_4;
  logic [DEN_W-1:0] dm_4;
  logic signed [AW-1:0] na_4;
  logic signed [BW-1:0] tb0_4, tb1_4, tb2_4;
  logic signed [TW-1:0] tc0_4, tc1_4, tc2_4;

  always_ff @(posedge clk) begin
    if (en) begin
      close_4 <= close_3;
      small_4 <= (64'(dm_c) <= 64'(det_eps)) || (dm_c == '0);
      dneg_4 <= det_3[DEN_W-1];
      dm_4 <= dm_c;
      na_4 <= na_3;
      tb0_4 <= BW'(y0_3) * BW'(sd12_3);
      tb1_4 <= BW'(y1_3) * BW'(sd02_3);
      tb2_4 <= BW'(y2_3) * BW'(sd01_3);
      tc0_4 <= TW'(yc0_3) * TW'(d12_3);
      tc1_4 <= TW'(yc1_3) * TW'(d02_3);
      tc2_4 <= TW'(yc2_3) * TW'(d01_3);
    end
  end

  // stage 5: status and the numerators of b and c
  fit_status_t stat_5;
  logic dneg_5;
  logic [DEN_W-1:0] dm_5;
  logic signed [NUM_W-1:0] na_5, nb_5, nc_5;

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (close_4) begin
        stat_5 <= FIT_CLOSE;
      end else if (small_4) begin
        stat_5 <= FIT_DET_SMALL;
      end else begin
        stat_5 <= FIT_OK;
      end
      dneg_5 <= dneg_4;
      dm_5 <= dm_4;
      na_5 <= NUM_W'(na_4);
      nb_5 <= NUM_W'(NBW'(tb1_4) - NBW'(tb0_4) - NBW'(tb2_4));
      nc_5 <= NUM_W'(NCW'(tc0_4) - NCW'(tc1_4) + NCW'(tc2_4));
    end
  end

  // stage 6: magnitudes and quotient signs for the dividers
  fit_status_t stat_6;
  logic [DEN_W-1:0] dm_6;
  logic [NUM_W-1:0] na_m, nb_m, nc_m;
  logic na_neg, nb_neg, nc_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      stat_6 <= stat_5;
      dm_6 <= dm_5;
      na_m <= $unsigned(na_5[NUM_W-1] ? -na_5 : na_5);
      nb_m <= $unsigned(nb_5[NUM_W-1] ? -nb_5 : nb_5);
      nc_m <= $unsigned(nc_5[NUM_W-1] ? -nc_5 : nc_5);
      na_neg <= na_5[NUM_W-1] ^ dneg_5;
      nb_neg <= nb_5[NUM_W-1] ^ dneg_5;
      nc_neg <= nc_5[NUM_W-1] ^ dneg_5;
    end
  end

  logic refuse_6;
  assign refuse_6 = stat_6 != FIT_OK;

  logic [OUT_W-1:0] qa, qb, qc;
  logic sa, sb, sc;

  qfit_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SHIFT(COORD_FRAC + COEF_FRAC)) u_div_a (
    .clk(clk), .en(en), .num_mag(na_m), .neg(na_neg), .den(dm_6), .refuse(refuse_6),
    .quo(qa), .sat(sa)
  );

  qfit_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SHIFT(COEF_FRAC)) u_div_b (
    .clk(clk), .en(en), .num_mag(nb_m), .neg(nb_neg), .den(dm_6), .refuse(refuse_6),
    .quo(qb), .sat(sb)
  );

  qfit_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SHIFT(COEF_FRAC - COORD_FRAC)) u_div_c (
    .clk(clk), .en(en), .num_mag(nc_m), .neg(nc_neg), .den(dm_6), .refuse(refuse_6),
    .quo(qc), .sat(sc)
  );

  // status travels alongside the dividers
  fit_status_t stat_d [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      stat_d[0] <= stat_6;
      for (int i = 1; i < DIV_LAT; i++) begin
        stat_d[i] <= stat_d[i-1];
      end
    end
  end

  assign m_axis_tvalid = v[NV-1];
  assign m_axis_tdata = {qc, qb, qa};
  assign m_axis_tuser = {sa | sb | sc, stat_d[DIV_LAT-1]};

`ifndef SYNTHESIS
  // a refused fit carries zero coefficients and no saturation
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1:0] != FIT_OK |-> m_axis_tdata == '0 && !m_axis_tuser[2])
    else $error("refused fit with nonzero coefficients");

  // saturation only on an accepted fit
  a_sat_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == FIT_OK)
    else $error("saturation flagged on refused fit");

  // input side is open exactly when the output is free or draining
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready inconsistent with output stall");

  // a taken transaction enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v[0])
    else $error("accepted transaction lost at entry");
`endif

endmodule
